FILE: design/svpd_pkg.sv
// ----------------------------------------------------------------------------
// svpd_pkg: shared types and constants for the SVPWM duty pipeline
// Angle and table geometry, fixed-point widths, the sine product table and
// the structs that carry items between pipeline stages.
// ----------------------------------------------------------------------------
package svpd_pkg;

    localparam int ANGLE_BITS           = 16;
    localparam int SINE_TABLE_ADDR_BITS = 10;

    localparam int SINE_IDX_W = SINE_TABLE_ADDR_BITS + 1;
    localparam int SINE_FULL  = 1 << SINE_TABLE_ADDR_BITS;

    // sqrt3 (Q1.15) times sine (Q1.15) fits in 31 bits
    localparam int PROD_W = 31;
    // rounded active voltage in mV
    localparam int D_W    = 16;
    // phase sum in half-millivolts, signed
    localparam int TWICE_W = 19;

    localparam logic [63:0] PI_3_Q30  = 64'd1124419809;
    localparam logic [63:0] SQRT3_Q15 = 64'd56756;
    localparam logic [63:0] ROUND_Q30 = 64'd536870912;

    localparam logic [14:0] BUS_VOLTAGE_RESET = 15'd12000;

    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    typedef logic [PROD_W-1:0] sine_rom_t [0:SINE_FULL];

    typedef struct packed {
        logic [2:0]            sec;
        logic [SINE_IDX_W-1:0] idx;
        logic [15:0]           mag;
    } sect_item_t;

    typedef struct packed {
        logic [2:0]     sec;
        logic [D_W-1:0] d1;
        logic [D_W-1:0] d2;
    } active_item_t;

    // Bring the 16-bit input angle to the internal angle width (truncating).
    function automatic logic [ANGLE_BITS-1:0] scale_angle(input logic [15:0] a);
        logic [ANGLE_BITS+15:0] wide;
        wide = {{ANGLE_BITS{1'b0}}, a};
        if (ANGLE_BITS >= 16) begin
            wide = wide << (ANGLE_BITS - 16);
        end else begin
            wide = wide >> (16 - ANGLE_BITS);
        end
        return wide[ANGLE_BITS-1:0];
    endfunction

    // Quantize the position within a sector to the table address width.
    function automatic logic [SINE_TABLE_ADDR_BITS-1:0] sector_index(
        input logic [ANGLE_BITS-1:0] u);
        logic [ANGLE_BITS+SINE_TABLE_ADDR_BITS-1:0] wide;
        wide = {{SINE_TABLE_ADDR_BITS{1'b0}}, u};
        if (ANGLE_BITS >= SINE_TABLE_ADDR_BITS) begin
            wide = wide >> (ANGLE_BITS - SINE_TABLE_ADDR_BITS);
        end else begin
            wide = wide << (SINE_TABLE_ADDR_BITS - ANGLE_BITS);
        end
        return wide[SINE_TABLE_ADDR_BITS-1:0];
    endfunction

    // Elaboration-time table: sqrt3 * sin(60deg * k / 2^N), both in Q1.15.
    // Sine comes from a Q30 Taylor series rounded to Q15.
    function automatic sine_rom_t build_sine_prod_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k <= SINE_FULL; k++) begin
            x  = (64'(k) * PI_3_Q30) >> SINE_TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            t  = (64'd1 << 30) - x2 / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            t  = (x * t) >> 30;
            s  = (t + (64'd1 << 14)) >> 15;
            rom[k] = PROD_W'(SQRT3_Q15 * s);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_PROD_ROM = build_sine_prod_rom();

endpackage

FILE: design/svpd_sector.sv
// ----------------------------------------------------------------------------
// svpd_sector: angle conditioning and sector search stage
// Folds a negative command into a half-turn rotation, adds a quarter turn,
// and splits the angle into sector number and table index.
// ----------------------------------------------------------------------------
module svpd_sector
    import svpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic signed [15:0] uq_voltage_mv,
    input  logic [15:0]       electrical_angle,
    output logic              out_valid,
    input  logic              out_ready,
    output sect_item_t        out_item
);

    logic                    valid_reg;
    sect_item_t              item_reg;
    sect_item_t              item_next;
    logic                    neg;
    logic [ANGLE_BITS-1:0]   ang_c;
    logic [ANGLE_BITS+2:0]   s6;

    always_comb begin
        neg   = uq_voltage_mv[15];
        ang_c = scale_angle(electrical_angle) + (neg ? ANGLE_HALF : '0) + ANGLE_QUARTER;
        s6    = {3'b000, ang_c} * (ANGLE_BITS + 3)'(6);
        item_next.sec = s6[ANGLE_BITS+2:ANGLE_BITS];
        item_next.idx = {1'b0, sector_index(s6[ANGLE_BITS-1:0])};
        // two's complement magnitude; the most negative command gives 0x8000
        item_next.mag = neg ? (~uq_voltage_mv + 16'd1) : uq_voltage_mv;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: design/svpd_active.sv
// ----------------------------------------------------------------------------
// svpd_active: active vector voltage stages
// Stage one reads sqrt3*sin for both active vectors from the table; stage
// two scales them by the command magnitude and rounds to millivolts.
// ----------------------------------------------------------------------------
module svpd_active
    import svpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  sect_item_t   in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output active_item_t out_item
);

    // table stage
    logic                  rom_valid_reg;
    logic                  rom_ready;
    logic [PROD_W-1:0]     p1_reg;
    logic [PROD_W-1:0]     p2_reg;
    logic [15:0]           mag_reg;
    logic [2:0]            rom_sec_reg;
    logic [SINE_IDX_W-1:0] idx_far;

    // multiply stage
    logic                  mul_valid_reg;
    logic                  mul_ready;
    active_item_t          mul_item_reg;
    active_item_t          mul_item_next;
    logic [PROD_W+15:0]    m1;
    logic [PROD_W+15:0]    m2;

    assign idx_far = SINE_IDX_W'(SINE_FULL) - in_item.idx;

    assign mul_ready = !mul_valid_reg || out_ready;
    assign rom_ready = !rom_valid_reg || mul_ready;
    assign in_ready  = rom_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else begin
            if (rom_ready) begin
                rom_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                mul_valid_reg <= rom_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rom_ready && in_valid) begin
            p1_reg      <= SINE_PROD_ROM[idx_far];
            p2_reg      <= SINE_PROD_ROM[in_item.idx];
            mag_reg     <= in_item.mag;
            rom_sec_reg <= in_item.sec;
        end
    end

    always_comb begin
        m1 = (PROD_W + 16)'(p1_reg) * (PROD_W + 16)'(mag_reg) + (PROD_W + 16)'(ROUND_Q30);
        m2 = (PROD_W + 16)'(p2_reg) * (PROD_W + 16)'(mag_reg) + (PROD_W + 16)'(ROUND_Q30);
        mul_item_next.sec = rom_sec_reg;
        mul_item_next.d1  = m1[30 +: D_W];
        mul_item_next.d2  = m2[30 +: D_W];
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && rom_valid_reg) begin
            mul_item_reg <= mul_item_next;
        end
    end

    assign out_valid = mul_valid_reg;
    assign out_item  = mul_item_reg;

endmodule

FILE: design/svpd_phase.sv
// ----------------------------------------------------------------------------
// svpd_phase: phase voltage combine, clamp and output register
// Forms center-aligned phase sums in half-millivolts per sector, halves
// with rounding and clamps to the range from zero to the bus voltage.
// ----------------------------------------------------------------------------
module svpd_phase
    import svpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [14:0]  bus_voltage_mv,
    input  logic         in_valid,
    output logic         in_ready,
    input  active_item_t in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [14:0]  phase_a_mv,
    output logic [14:0]  phase_b_mv,
    output logic [14:0]  phase_c_mv,
    output logic [2:0]   sector
);

    logic                      valid_reg;
    logic [14:0]               pa_reg;
    logic [14:0]               pb_reg;
    logic [14:0]               pc_reg;
    logic [2:0]                sec_reg;
    logic signed [TWICE_W-1:0] vb;
    logic signed [TWICE_W-1:0] d1;
    logic signed [TWICE_W-1:0] d2;
    logic signed [TWICE_W-1:0] a2;
    logic signed [TWICE_W-1:0] b2;
    logic signed [TWICE_W-1:0] c2;

    function automatic logic [14:0] clamp_phase(input logic signed [TWICE_W-1:0] twice,
                                                input logic [14:0] vbus);
        logic [TWICE_W-1:0] half;
        logic [14:0]        res;
        half = TWICE_W'(twice + TWICE_W'(1)) >> 1;
        if (twice <= 0) begin
            res = '0;
        end else if (half > TWICE_W'(vbus)) begin
            res = vbus;
        end else begin
            res = half[14:0];
        end
        return res;
    endfunction

    always_comb begin
        vb = TWICE_W'(bus_voltage_mv);
        d1 = TWICE_W'(in_item.d1);
        d2 = TWICE_W'(in_item.d2);
        unique case (in_item.sec)
            3'd0: begin
                a2 = vb + d1 + d2; b2 = vb - d1 + d2; c2 = vb - d1 - d2;
            end
            3'd1: begin
                a2 = vb + d1 - d2; b2 = vb + d1 + d2; c2 = vb - d1 - d2;
            end
            3'd2: begin
                a2 = vb - d1 - d2; b2 = vb + d1 + d2; c2 = vb - d1 + d2;
            end
            3'd3: begin
                a2 = vb - d1 - d2; b2 = vb + d1 - d2; c2 = vb + d1 + d2;
            end
            3'd4: begin
                a2 = vb - d1 + d2; b2 = vb - d1 - d2; c2 = vb + d1 + d2;
            end
            default: begin
                a2 = vb + d1 + d2; b2 = vb - d1 - d2; c2 = vb + d1 - d2;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pa_reg  <= clamp_phase(a2, bus_voltage_mv);
            pb_reg  <= clamp_phase(b2, bus_voltage_mv);
            pc_reg  <= clamp_phase(c2, bus_voltage_mv);
            sec_reg <= in_item.sec + 3'd1;
        end
    end

    assign out_valid  = valid_reg;
    assign phase_a_mv = pa_reg;
    assign phase_b_mv = pb_reg;
    assign phase_c_mv = pc_reg;
    assign sector     = sec_reg;

endmodule

FILE: design/space_vector_pwm_duty_top.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_top: space vector PWM phase voltage generator
// Turns a signed q-axis voltage command and an electrical angle into three
// center-aligned average phase voltages and the selected sector.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output is not stalled
// and returns one result per transaction, in the order they were accepted.
// Its four register stages are: angle conditioning and sector search, the
// sqrt3*sine table read, the magnitude multiply with rounding, and the
// phase combine/clamp stage, which is also the output register. Back
// pressure on the result side holds each stage only while the stage below
// it is full, so bubbles are squeezed out before the input stalls.
// The bus voltage register (reset 12000 mV) is written through the cfg
// channel, which is always ready; write it only while no transaction is in
// flight. Phase outputs saturate to 0..bus voltage on overmodulation.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_top
    import svpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] uq_voltage_mv (signed), [31:16] electrical_angle
    input  logic [31:0] s_tdata,

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] phase_a_mv, [29:15] phase_b_mv, [44:30] phase_c_mv, [47:45] sector
    output logic [47:0] m_tdata,

    // bus voltage register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    logic [14:0]  bus_voltage_mv_reg;

    logic         sect_valid;
    logic         sect_ready;
    sect_item_t   sect_item;
    logic         act_valid;
    logic         act_ready;
    active_item_t act_item;

    logic [14:0]  phase_a_mv;
    logic [14:0]  phase_b_mv;
    logic [14:0]  phase_c_mv;
    logic [2:0]   sector;

    // Always ready; the user, not the block, keeps the register idle-only.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_voltage_mv_reg <= BUS_VOLTAGE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bus_voltage_mv_reg <= cfg_data;
        end
    end

    // Stage 1: fold sign into angle, find sector and table index.
    svpd_sector u_sector (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .uq_voltage_mv    (s_tdata[15:0]),
        .electrical_angle (s_tdata[31:16]),
        .out_valid        (sect_valid),
        .out_ready        (sect_ready),
        .out_item         (sect_item)
    );

    // Stages 2 and 3: table read, then scale by magnitude.
    svpd_active u_active (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_item   (sect_item),
        .out_valid (act_valid),
        .out_ready (act_ready),
        .out_item  (act_item)
    );

    // Stage 4: combine, clamp, hold the result until taken.
    svpd_phase u_phase (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .bus_voltage_mv (bus_voltage_mv_reg),
        .in_valid       (act_valid),
        .in_ready       (act_ready),
        .in_item        (act_item),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .phase_a_mv     (phase_a_mv),
        .phase_b_mv     (phase_b_mv),
        .phase_c_mv     (phase_c_mv),
        .sector         (sector)
    );

    assign m_tdata = {sector, phase_c_mv, phase_b_mv, phase_a_mv};

    // Sector on the output is always one to six.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sector >= 3'd1 && sector <= 3'd6))
        else $error("sector out of range");

    // Clamp keeps every phase within the bus voltage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (phase_a_mv <= bus_voltage_mv_reg &&
                      phase_b_mv <= bus_voltage_mv_reg &&
                      phase_c_mv <= bus_voltage_mv_reg))
        else $error("phase above bus voltage");

    // The input only stalls when the full pipeline is blocked at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back pressure");

endmodule

FILE: test/tb_space_vector_pwm_duty_top.sv
// ----------------------------------------------------------------------------
// tb_space_vector_pwm_duty_top: self-checking bench for the SVPWM duty block
// Drives q-axis voltage commands and electrical angles into the command
// stream, predicts the three clamped phase voltages and the sector for each
// accepted transaction, and compares every result transaction in order.
// The bus voltage register is swept through several settings between
// bursts, with random idle bursts on both streams in all but the last burst.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_duty_top;
    import svpd_pkg::*;

    localparam int SETTLE_CYCLES     = 8;     // beyond the four-stage pipeline
    localparam int WATCHDOG_LIMIT    = 2000;  // quiet cycles before giving up
    localparam int ITEMS_PER_SETTING = 210;
    localparam int MAX_SHOWN         = 10;
    localparam int N_SETTINGS        = 7;
    localparam int N_DIRECTED        = 22;

    // One result transaction, laid out exactly as m_tdata:
    // [14:0] phase_a_mv, [29:15] phase_b_mv, [44:30] phase_c_mv, [47:45] sector
    typedef struct packed {
        logic [2:0]  sector;
        logic [14:0] phase_c;
        logic [14:0] phase_b;
        logic [14:0] phase_a;
    } phase_set_t;

    // One directed command; res holds a typed-in answer when typed_in is set
    typedef struct {
        logic signed [15:0] uq;
        logic [15:0]        angle;
        bit                 typed_in;
        phase_set_t         res;
    } cmd_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [15:0] uq_voltage_mv, [31:16] electrical_angle
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;           // phase_a, phase_b, phase_c, sector (low bits first)
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data  = '0;

    // Predictor state: the sine table and the bus voltage the block holds now
    longint      sine_q15 [0:SINE_FULL];
    logic [14:0] bus_now = BUS_VOLTAGE_RESET;

    phase_set_t  pending_phases [$];   // expected results, oldest first
    int          err_count   = 0;
    int          checked     = 0;
    int          cmds_sent   = 0;
    int          quiet       = 0;
    int          stall_left  = 0;
    bit          idling_on   = 1'b1;

    // Directed commands, all under the reset bus voltage of 12000 mV.
    // Zero command: every phase sits at half the bus, sector from the angle alone.
    // Full command at sector start: phase A pins to the bus, B and C to zero.
    cmd_row_t dir_rows [0:N_DIRECTED-1] = '{
        '{16'sd0,      16'd0,     1'b1, {3'd2, 15'd6000, 15'd6000, 15'd6000}},
        '{16'sd0,      16'd16384, 1'b1, {3'd4, 15'd6000, 15'd6000, 15'd6000}},
        '{16'sd0,      16'd32768, 1'b1, {3'd5, 15'd6000, 15'd6000, 15'd6000}},
        '{16'sd0,      16'd49152, 1'b1, {3'd1, 15'd6000, 15'd6000, 15'd6000}},
        '{16'sd32767,  16'd49152, 1'b1, {3'd1, 15'd0, 15'd0, 15'd12000}},
        // most negative command: magnitude 32768, angle turned by half
        '{16'sh8000,   16'd16384, 1'b1, {3'd1, 15'd0, 15'd0, 15'd12000}},
        '{16'sh8000,   16'd65535, 1'b0, '0},
        '{16'sd32767,  16'd65535, 1'b0, '0},
        '{-16'sd1,     16'd0,     1'b0, '0},
        '{16'sd1,      16'd65535, 1'b0, '0},
        // one command in the middle of each sector
        '{16'sd6000,   16'd54613, 1'b0, '0},
        '{16'sd6000,   16'd0,     1'b0, '0},
        '{16'sd6000,   16'd10923, 1'b0, '0},
        '{16'sd6000,   16'd21846, 1'b0, '0},
        '{16'sd6000,   16'd32769, 1'b0, '0},
        '{16'sd6000,   16'd43692, 1'b0, '0},
        // overmodulation inside a sector, negative commands, bit patterns
        '{16'sd32767,  16'd10923, 1'b0, '0},
        '{-16'sd20000, 16'd21846, 1'b0, '0},
        '{16'sh5555,   16'hAAAA,  1'b0, '0},
        '{16'shAAAA,   16'h5555,  1'b0, '0},
        // last table step of sector 1 and first step of sector 2
        '{16'sd9000,   16'd60074, 1'b0, '0},
        '{16'sd9000,   16'd60075, 1'b0, '0}
    };

    space_vector_pwm_duty_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Round half up from half-millivolts, then saturate to 0..vbus.
    function automatic logic [14:0] clamp_half_mv(input longint twice, input longint vb);
        longint v;
        if (twice <= 0) begin
            return '0;
        end
        v = (twice + 1) >>> 1;
        if (v > vb) begin
            v = vb;
        end
        return 15'(v);
    endfunction

    // Work out the phase voltages and sector for one command.
    function automatic phase_set_t predict_phases(input logic [15:0] uq_bits,
                                                  input logic [15:0] angle16,
                                                  input logic [14:0] vbus);
        logic [63:0] ang;
        logic [63:0] s6;
        logic [63:0] u;
        longint      mag;
        longint      d1;
        longint      d2;
        longint      vb;
        longint      a2;
        longint      b2;
        longint      c2;
        int          sec;
        int          idx;
        phase_set_t  r;
        ang = 64'(angle16);
        if (ANGLE_BITS >= 16) begin
            ang = ang << (ANGLE_BITS - 16);
        end else begin
            ang = ang >> (16 - ANGLE_BITS);
        end
        // negative command: turn by half and keep the magnitude
        if ($signed(uq_bits) < 0) begin
            ang = ang + (64'd1 << (ANGLE_BITS - 1));
            mag = -longint'($signed(uq_bits));
        end else begin
            mag = longint'($signed(uq_bits));
        end
        ang = (ang + (64'd1 << (ANGLE_BITS - 2))) & ((64'd1 << ANGLE_BITS) - 1);
        s6  = ang * 64'd6;
        sec = int'(s6 >> ANGLE_BITS);
        u   = s6 - (64'(sec) << ANGLE_BITS);
        if (ANGLE_BITS >= SINE_TABLE_ADDR_BITS) begin
            idx = int'(u >> (ANGLE_BITS - SINE_TABLE_ADDR_BITS));
        end else begin
            idx = int'(u << (SINE_TABLE_ADDR_BITS - ANGLE_BITS));
        end
        if (idx > SINE_FULL) begin
            idx = SINE_FULL;
        end
        d1 = (longint'(SQRT3_Q15) * sine_q15[SINE_FULL - idx] * mag + (64'sd1 <<< 29)) >>> 30;
        d2 = (longint'(SQRT3_Q15) * sine_q15[idx] * mag + (64'sd1 <<< 29)) >>> 30;
        vb = longint'(vbus);
        case (sec)
            0: begin
                a2 = vb + d1 + d2; b2 = vb - d1 + d2; c2 = vb - d1 - d2;
            end
            1: begin
                a2 = vb + d1 - d2; b2 = vb + d1 + d2; c2 = vb - d1 - d2;
            end
            2: begin
                a2 = vb - d1 - d2; b2 = vb + d1 + d2; c2 = vb - d1 + d2;
            end
            3: begin
                a2 = vb - d1 - d2; b2 = vb + d1 - d2; c2 = vb + d1 + d2;
            end
            4: begin
                a2 = vb - d1 + d2; b2 = vb - d1 - d2; c2 = vb + d1 + d2;
            end
            default: begin
                a2 = vb + d1 + d2; b2 = vb - d1 - d2; c2 = vb + d1 - d2;
            end
        endcase
        r.phase_a = clamp_half_mv(a2, vb);
        r.phase_b = clamp_half_mv(b2, vb);
        r.phase_c = clamp_half_mv(c2, vb);
        r.sector  = 3'(sec + 1);
        return r;
    endfunction

    // Offer one command, optionally after an idle burst, and record its
    // expected result once the transaction is accepted. Call at a clock edge.
    task automatic push_cmd(input logic [15:0] uq, input logic [15:0] angle,
                            input phase_set_t want);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {angle, uq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_phases.push_back(want);
        cmds_sent++;
    endtask

    // Stop offering commands and wait until every expected result is back,
    // then let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_phases.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the bus voltage register; only called with the pipeline empty.
    task automatic write_bus(input logic [14:0] mv);
        cfg_valid <= 1'b1;
        cfg_data  <= mv;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        bus_now = mv;
    endtask

    // Result side back pressure: random stall bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        phase_set_t got;
        phase_set_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = phase_set_t'(m_tdata);
            if (pending_phases.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN) begin
                    $display("unexpected result: a=%0d b=%0d c=%0d sector=%0d",
                             got.phase_a, got.phase_b, got.phase_c, got.sector);
                end
            end else begin
                want = pending_phases.pop_front();
                checked++;
                if (got.phase_a !== want.phase_a || got.phase_b !== want.phase_b ||
                    got.phase_c !== want.phase_c || got.sector !== want.sector) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN) begin
                        $display("result %0d (vbus %0d): expected a=%0d b=%0d c=%0d sector=%0d",
                                 checked, bus_now, want.phase_a, want.phase_b,
                                 want.phase_c, want.sector);
                        $display("    got a=%0d b=%0d c=%0d sector=%0d",
                                 got.phase_a, got.phase_b, got.phase_c, got.sector);
                    end
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_phases.size());
            $display("tb_space_vector_pwm_duty_top: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [14:0] bus_plan [N_SETTINGS];
        logic [15:0] uq;
        logic [15:0] angle;
        int          mag;
        int          k;

        // Build the Q1.15 sine table for 60 degrees from a Q30 Taylor series
        for (int i = 0; i <= SINE_FULL; i++) begin
            x  = (64'(i) * PI_3_Q30) >> SINE_TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            t  = (64'd1 << 30) - x2 / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            t  = (x * t) >> 30;
            sine_q15[i] = longint'((t + (64'd1 << 14)) >> 15);
        end

        // Sweep: both extremes, zero bus, typical and random settings
        bus_plan[0] = 15'd32767;
        bus_plan[1] = 15'd1;
        bus_plan[2] = 15'd0;
        bus_plan[3] = 15'($urandom_range(1, 32767));
        bus_plan[4] = 15'd12000;
        bus_plan[5] = 15'($urandom_range(1, 32767));
        bus_plan[6] = 15'($urandom_range(1000, 32767));

        // Hold reset from time zero, then release it for good
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands under the reset bus voltage
        foreach (dir_rows[i]) begin
            push_cmd(dir_rows[i].uq, dir_rows[i].angle,
                     dir_rows[i].typed_in ? dir_rows[i].res
                                          : predict_phases(dir_rows[i].uq,
                                                           dir_rows[i].angle, bus_now));
        end

        // Random commands, one burst per bus voltage setting; the last burst
        // runs with no idling on either side
        for (int p = 0; p < N_SETTINGS; p++) begin
            idling_on = (p != N_SETTINGS - 1);
            drain_results();
            write_bus(bus_plan[p]);
            repeat (ITEMS_PER_SETTING) begin
                case ($urandom_range(0, 4))
                    0: begin
                        uq = 16'($urandom);
                    end
                    1: begin
                        mag = $urandom_range(0, 2000);
                        uq  = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                    end
                    2: begin
                        mag = $urandom_range(0, 64);
                        uq  = $urandom_range(0, 1) ? 16'(32767 - mag) : 16'(-32768 + mag);
                    end
                    default: begin
                        mag = $urandom_range(0, 16000);
                        uq  = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                    end
                endcase
                // a quarter of the angles land within a few counts of a
                // sector boundary
                if ($urandom_range(0, 3) == 0) begin
                    k     = $urandom_range(0, 5);
                    angle = 16'(k * 10923 - 16384 + $urandom_range(0, 6) - 3);
                end else begin
                    angle = 16'($urandom);
                end
                push_cmd(uq, angle, predict_phases(uq, angle, bus_now));
            end
        end

        drain_results();
        if (pending_phases.size() != 0) begin
            err_count++;
            $display("%0d expected results never arrived", pending_phases.size());
        end
        $display("ran %0d commands (%0d directed) over %0d bus voltage settings",
                 cmds_sent, N_DIRECTED, N_SETTINGS + 1);
        $display("bus extremes 0, 1 and 32767 included; %0d results checked, %0d mismatches",
                 checked, err_count);
        if (err_count == 0) begin
            $display("tb_space_vector_pwm_duty_top: clean");
        end else begin
            $display("tb_space_vector_pwm_duty_top: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
design/svpd_pkg.sv
design/svpd_sector.sv
design/svpd_active.sv
design/svpd_phase.sv
design/space_vector_pwm_duty_top.sv
test/tb_space_vector_pwm_duty_top.sv
